// ----- design/pmc_pkg.sv -----
// Shared types, constants and helpers of the palette/material colorizer.
package pmc_pkg;

  localparam logic [15:0] TRANSPARENT_VALUE = 16'd63519;
  localparam logic [31:0] LCG_MUL           = 32'd1103515245;
  localparam logic [31:0] LCG_INC           = 32'd12345;
  localparam logic [7:0]  MAT_BASE          = 8'd192;
  localparam logic [10:0] CHAN_MAX          = 11'h7FF;
  localparam int          QUEUE_DEPTH       = 4;
  localparam int          QUEUE_AW          = $clog2(QUEUE_DEPTH);
  localparam int          PADDR_W           = 5;

  typedef enum logic [2:0] {
    REG_MAT_LO,
    REG_MAT_HI,
    REG_RUST,
    REG_BURN,
    REG_MAT_ALPHA,
    REG_BASE_ALPHA,
    REG_ALLOW_PAL
  } reg_idx_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] pixel_code;
    logic       image_start;
    logic [7:0] pal_addr;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;
  } in_t;

  typedef struct packed {
    logic [15:0] rgb565;
    logic [7:0]  alpha;
  } out_t;

  typedef struct packed {
    logic [31:0] material_colors_low;
    logic [31:0] material_colors_high;
    logic [31:0] rust_levels;
    logic [31:0] burn_levels;
    logic [31:0] material_alphas;
    logic [7:0]  base_alpha;
    logic        allow_palette;
  } cfg_t;

  typedef struct packed {
    logic        is_mat;
    logic        image_start;
    logic [1:0]  mat_idx;
    logic [3:0]  shade;
    logic [15:0] rgb;
  } q_entry_t;

  function automatic logic [7:0] byte_of(input logic [31:0] word, input logic [1:0] idx);
    byte_of = word[{idx, 3'b000} +: 8];
  endfunction

endpackage

// ----- design/pmc_front.sv -----
// Front end: accepts transactions, owns the palette memory, classifies pixels.
module pmc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  pmc_pkg::in_t      in_data,
  input  logic              allow_palette,
  output logic              push,
  output pmc_pkg::q_entry_t push_data,
  input  logic              q_full
);
  import pmc_pkg::*;

  logic [23:0] pal_mem [256];
  logic [23:0] rd_data;
  logic        accept;
  logic        pix_accept;
  logic        f_valid;
  logic [7:0]  f_code;
  logic        f_start;

  assign in_stall   = f_valid && q_full;
  assign accept     = in_valid && !in_stall;
  assign pix_accept = accept && !in_data.req_type;

  always_ff @(posedge clk) begin
    if (accept && in_data.req_type) begin
      pal_mem[in_data.pal_addr] <= {in_data.pal_red, in_data.pal_green, in_data.pal_blue};
    end
    if (pix_accept) begin
      rd_data <= pal_mem[in_data.pixel_code];
      f_code  <= in_data.pixel_code;
      f_start <= in_data.image_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= (f_valid && q_full) || pix_accept;
    end
  end

  assign push = f_valid && !q_full;

  always_comb begin
    push_data.is_mat      = (f_code >= MAT_BASE);
    push_data.image_start = f_start;
    push_data.mat_idx     = f_code[5:4];
    push_data.shade       = f_code[3:0];
    push_data.rgb         = allow_palette ? {rd_data[23:19], rd_data[15:10], rd_data[7:3]}
                                          : TRANSPARENT_VALUE;
  end

endmodule

// ----- design/pmc_queue.sv -----
// Short FIFO between the front end and the back end.
module pmc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pmc_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output pmc_pkg::q_entry_t pop_data,
  output logic              not_empty
);
  import pmc_pkg::*;

  q_entry_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !not_empty))
    else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not follow pop");

endmodule

// ----- design/pmc_back.sv -----
// Back end: seed LCGs, material shading, rust/burn and output register.
module pmc_back (
  input  logic              clk,
  input  logic              rst,
  input  pmc_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  pmc_pkg::q_entry_t q_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output pmc_pkg::out_t     out_data
);
  import pmc_pkg::*;

  function automatic logic [10:0] sat11(input logic [11:0] v);
    sat11 = v[11] ? CHAN_MAX : v[10:0];
  endfunction

  logic [31:0] rust_seeds [4];
  logic [31:0] burn_seeds [4];

  logic        a_load;
  logic        b_load;
  logic        a_valid;
  logic        a_draw;
  logic        a_rust;
  logic        a_burn;
  logic [15:0] a_rgb;
  logic [7:0]  a_alpha;
  logic [11:0] a_r;
  logic [11:0] a_g;
  logic [11:0] a_b;
  logic [11:0] a_mx;

  logic [1:0]  m;
  logic [15:0] col;
  logic        draw;
  logic [7:0]  rust_lvl;
  logic [7:0]  burn_lvl;
  logic [31:0] rust_cur;
  logic [31:0] burn_cur;
  logic [31:0] rust_prod;
  logic [31:0] burn_prod;
  logic        rust_step;
  logic        burn_step;
  logic        rust_hit;
  logic        burn_hit;
  logic [11:0] sc_r;
  logic [11:0] sc_g;
  logic [11:0] sc_b;
  logic [11:0] sc_mx;

  assign b_load = !out_valid || !out_stall;
  assign a_load = !a_valid || b_load;
  assign pop    = q_valid && a_load;

  always_comb begin
    m         = q_data.mat_idx;
    col       = m[1] ? cfg.material_colors_high[{m[0], 4'b0000} +: 16]
                     : cfg.material_colors_low[{m[0], 4'b0000} +: 16];
    draw      = q_data.is_mat && (col != TRANSPARENT_VALUE);
    rust_lvl  = byte_of(cfg.rust_levels, m);
    burn_lvl  = byte_of(cfg.burn_levels, m);
    rust_cur  = q_data.image_start ? {26'd0, rust_lvl[7:2]} : rust_seeds[m];
    burn_cur  = q_data.image_start ? {26'd0, burn_lvl[7:2]} : burn_seeds[m];
    rust_prod = rust_cur * LCG_MUL + LCG_INC;
    burn_prod = burn_cur * LCG_MUL + LCG_INC;
    rust_step = draw && (rust_lvl != 8'd0);
    burn_step = draw && (burn_lvl != 8'd0);
    rust_hit  = rust_step && (rust_lvl[1:0] > rust_prod[31:30]);
    burn_hit  = burn_step && (burn_lvl[1:0] > burn_prod[31:30]);
    sc_r      = {col[15:11], 3'b000} * q_data.shade;
    sc_g      = {col[10:5], 2'b00} * q_data.shade;
    sc_b      = {col[4:0], 3'b000} * q_data.shade;
    sc_mx     = (sc_r > sc_g) ? sc_r : sc_g;
    if (sc_b > sc_mx) begin
      sc_mx = sc_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        rust_seeds[i] <= '0;
        burn_seeds[i] <= '0;
      end
    end else if (pop) begin
      for (int i = 0; i < 4; i++) begin
        if (q_data.image_start) begin
          rust_seeds[i] <= {26'd0, cfg.rust_levels[8*i+2 +: 6]};
          burn_seeds[i] <= {26'd0, cfg.burn_levels[8*i+2 +: 6]};
        end
      end
      if (rust_step) begin
        rust_seeds[m] <= rust_prod;
      end
      if (burn_step) begin
        burn_seeds[m] <= burn_prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_draw  <= draw;
      a_rust  <= rust_hit;
      a_burn  <= burn_hit;
      a_rgb   <= q_data.is_mat ? TRANSPARENT_VALUE : q_data.rgb;
      a_alpha <= draw ? byte_of(cfg.material_alphas, m) : cfg.base_alpha;
      a_r     <= sc_r;
      a_g     <= sc_g;
      a_b     <= sc_b;
      a_mx    <= sc_mx;
    end
  end

  logic [13:0] g_x3;
  logic [11:0] g_rust;
  logic [11:0] b_rust;
  logic [9:0]  mq;
  logic [11:0] r_fin;
  logic [11:0] g_fin;
  logic [11:0] b_fin;
  logic [10:0] r_sat;
  logic [10:0] g_sat;
  logic [10:0] b_sat;
  out_t        b_next;

  always_comb begin
    g_x3   = {2'b00, a_g} + {1'b0, a_g, 1'b0};
    g_rust = a_rust ? g_x3[13:2] : a_g;
    b_rust = a_rust ? {1'b0, a_b[11:1]} : a_b;
    mq     = a_mx[11:2];
    r_fin  = a_burn ? {2'b00, mq} + {3'b000, a_r[11:3]} : a_r;
    g_fin  = a_burn ? {2'b00, mq} + {3'b000, g_rust[11:3]} : g_rust;
    b_fin  = a_burn ? {2'b00, mq} + {3'b000, b_rust[11:3]} : b_rust;
    r_sat  = sat11(r_fin);
    g_sat  = sat11(g_fin);
    b_sat  = sat11(b_fin);
    b_next.rgb565 = a_draw ? {r_sat[10:6], g_sat[10:5], b_sat[10:6]} : a_rgb;
    b_next.alpha  = a_alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_load) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load && a_valid) begin
      out_data <= b_next;
    end
  end

endmodule

// ----- design/palette_material_colorizer.sv -----
// Palette/material colorizer top level: register file and front/queue/back hookup.
// Takes one transaction per clock while in_stall is low and gives one RGB565+alpha
// result per pixel transaction; palette writes give none. A pixel passes the
// palette read register, a four-entry queue, the seed/shading stage and the
// output register. Throughput is one pixel per cycle when the output does not
// stall, set by the per-material seed updates, two 32x32 multiplies in the back
// end whose results feed back into the seed registers. The queue lets the input
// side keep going while the output stalls, until it fills.
module palette_material_colorizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pmc_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pmc_pkg::out_t                 out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmc_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pmc_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     wr_en;

  logic     push;
  q_entry_t push_data;
  logic     q_full;
  logic     pop;
  q_entry_t pop_data;
  logic     q_valid;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.material_colors_low  <= '0;
      cfg.material_colors_high <= '0;
      cfg.rust_levels          <= '0;
      cfg.burn_levels          <= '0;
      cfg.material_alphas      <= '1;
      cfg.base_alpha           <= 8'hFF;
      cfg.allow_palette        <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MAT_LO:     cfg.material_colors_low  <= pwdata;
        REG_MAT_HI:     cfg.material_colors_high <= pwdata;
        REG_RUST:       cfg.rust_levels          <= pwdata;
        REG_BURN:       cfg.burn_levels          <= pwdata;
        REG_MAT_ALPHA:  cfg.material_alphas      <= pwdata;
        REG_BASE_ALPHA: cfg.base_alpha           <= pwdata[7:0];
        REG_ALLOW_PAL:  cfg.allow_palette        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAT_LO:     prdata = cfg.material_colors_low;
      REG_MAT_HI:     prdata = cfg.material_colors_high;
      REG_RUST:       prdata = cfg.rust_levels;
      REG_BURN:       prdata = cfg.burn_levels;
      REG_MAT_ALPHA:  prdata = cfg.material_alphas;
      REG_BASE_ALPHA: prdata = {24'd0, cfg.base_alpha};
      REG_ALLOW_PAL:  prdata = {31'd0, cfg.allow_palette};
      default:        prdata = '0;
    endcase
  end

  pmc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .allow_palette (cfg.allow_palette),
    .push          (push),
    .push_data     (push_data),
    .q_full        (q_full)
  );

  pmc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  pmc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- verif/testbench.sv -----
// Testbench of the palette/material colorizer: directed table, then random phases checked against a local predictor.
`timescale 1ns / 100ps

module testbench;
  import pmc_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 155;
  localparam int DRAIN_CYCLES  = 8;

  typedef enum {STEP_PIXEL, STEP_PALETTE, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    in_t         item;
    reg_idx_t    idx;
    logic [31:0] value;
    bit          typed;
    out_t        want;
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  palette_material_colorizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  cfg_t        regs;
  logic [23:0] pal_mem [256];
  logic [31:0] rust_seed [4];
  logic [31:0] burn_seed [4];

  out_t        colors_due [$];
  bit          pal_written [256];
  logic [7:0]  pal_codes [$];
  step_t       steps [$];

  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  int          tx_calm = 0;
  int          stall_left = 0;
  int          calm_left = 0;
  out_t        got_want;

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic bit lcg_advance(inout logic [31:0] seed, input logic [7:0] lvl);
    if (lvl == 8'd0) return 1'b0;
    seed = seed * LCG_MUL + LCG_INC;
    return lvl[1:0] > seed[31:30];
  endfunction

  function automatic logic [31:0] sat_chan(input logic [31:0] v);
    return (v > 32'(CHAN_MAX)) ? 32'(CHAN_MAX) : v;
  endfunction

  // Returns 1 when the transaction yields a pixel color.
  function automatic bit colorize(input in_t it, output out_t res);
    logic [1:0]  m;
    logic [15:0] col;
    logic [31:0] r, g, b, mx, shade;
    logic [23:0] e;
    res = '0;
    if (it.req_type) begin
      pal_mem[it.pal_addr] = {it.pal_red, it.pal_green, it.pal_blue};
      return 1'b0;
    end
    if (it.image_start) begin
      for (int i = 0; i < 4; i++) begin
        rust_seed[i] = 32'(regs.rust_levels[8*i +: 8] >> 2);
        burn_seed[i] = 32'(regs.burn_levels[8*i +: 8] >> 2);
      end
    end
    res.alpha = regs.base_alpha;
    if (it.pixel_code >= MAT_BASE) begin
      m = it.pixel_code[5:4];
      col = m[1] ? regs.material_colors_high[16*m[0] +: 16]
                 : regs.material_colors_low[16*m[0] +: 16];
      if (col == TRANSPARENT_VALUE) begin
        res.rgb565 = TRANSPARENT_VALUE;
      end else begin
        shade = 32'(it.pixel_code[3:0]);
        r = 32'({col[15:11], 3'b000}) * shade;
        g = 32'({col[10:5], 2'b00}) * shade;
        b = 32'({col[4:0], 3'b000}) * shade;
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;
        if (lcg_advance(rust_seed[m], regs.rust_levels[8*m +: 8])) begin
          g = ((g << 1) + g) >> 2;
          b = b >> 1;
        end
        if (lcg_advance(burn_seed[m], regs.burn_levels[8*m +: 8])) begin
          mx = mx >> 2;
          r = mx + (r >> 3);
          g = mx + (g >> 3);
          b = mx + (b >> 3);
        end
        r = sat_chan(r);
        g = sat_chan(g);
        b = sat_chan(b);
        res.rgb565 = {r[10:6], g[10:5], b[10:6]};
        res.alpha = regs.material_alphas[8*m +: 8];
      end
    end else if (regs.allow_palette) begin
      e = pal_mem[it.pixel_code];
      res.rgb565 = {e[23:19], e[15:10], e[7:3]};
    end else begin
      res.rgb565 = TRANSPARENT_VALUE;
    end
    return 1'b1;
  endfunction

  function automatic step_t pix(input logic [7:0] code, input logic start, input bit typed = 0,
                                input logic [15:0] rgb = '0, input logic [7:0] a = '0);
    step_t s;
    s.kind = STEP_PIXEL;
    s.item = in_t'(42'({$urandom, $urandom}));
    s.item.req_type = 1'b0;
    s.item.pixel_code = code;
    s.item.image_start = start;
    s.idx = REG_MAT_LO;
    s.value = '0;
    s.typed = typed;
    s.want = '{rgb565: rgb, alpha: a};
    return s;
  endfunction

  function automatic step_t pal(input logic [7:0] addr, input logic [23:0] rgb);
    step_t s;
    s = pix(8'd0, 1'b0);
    s.kind = STEP_PALETTE;
    s.item.req_type = 1'b1;
    s.item.pal_addr = addr;
    {s.item.pal_red, s.item.pal_green, s.item.pal_blue} = rgb;
    return s;
  endfunction

  function automatic step_t reg_wr(input reg_idx_t idx, input logic [31:0] v);
    step_t s;
    s = pix(8'd0, 1'b0);
    s.kind = STEP_REG;
    s.idx = idx;
    s.value = v;
    return s;
  endfunction

  function automatic logic [7:0] mix_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] mix_color();
    case ($urandom_range(0, 7))
      0, 1: return TRANSPARENT_VALUE;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MAT_LO:     regs.material_colors_low = v;
      REG_MAT_HI:     regs.material_colors_high = v;
      REG_RUST:       regs.rust_levels = v;
      REG_BURN:       regs.burn_levels = v;
      REG_MAT_ALPHA:  regs.material_alphas = v;
      REG_BASE_ALPHA: regs.base_alpha = v[7:0];
      REG_ALLOW_PAL:  regs.allow_palette = v[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_item(input in_t it, input bit typed, input out_t want);
    out_t res;
    int   roll;
    if (!quiet) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else begin
        roll = $urandom_range(0, 31);
        if (roll < 4) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk);
        end else if (roll == 4) begin
          tx_calm = $urandom_range(20, 120);
        end
      end
    end
    if (it.req_type && !pal_written[it.pal_addr]) begin
      pal_written[it.pal_addr] = 1'b1;
      if (it.pal_addr < MAT_BASE) pal_codes.push_back(it.pal_addr);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (colorize(it, res)) colors_due.push_back(typed ? want : res);
  endtask

  // result side: random stall bursts with calm stretches
  always @(posedge clk) begin
    int roll;
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm_left != 0) begin
      out_stall <= 1'b0;
      calm_left <= calm_left - 1;
    end else begin
      out_stall <= 1'b0;
      roll = $urandom_range(0, 31);
      if (roll < 4) stall_left <= $urandom_range(1, 13);
      else if (roll == 4) calm_left <= $urandom_range(20, 120);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (colors_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction rgb565=%h alpha=%h",
                                out_data.rgb565, out_data.alpha));
      end else begin
        got_want = colors_due.pop_front();
        if (out_data.rgb565 !== got_want.rgb565)
          flag_mismatch($sformatf("rgb565 %h, expected %h", out_data.rgb565, got_want.rgb565));
        if (out_data.alpha !== got_want.alpha)
          flag_mismatch($sformatf("alpha %h, expected %h", out_data.alpha, got_want.alpha));
      end
    end
  end

  initial begin
    in_t it;
    out_t none;
    none = '0;
    regs = '{material_colors_low: '0, material_colors_high: '0, rust_levels: '0,
             burn_levels: '0, material_alphas: '1, base_alpha: 8'hFF, allow_palette: 1'b1};
    for (int i = 0; i < 4; i++) begin
      rust_seed[i] = '0;
      burn_seed[i] = '0;
    end
    for (int i = 0; i < 256; i++) begin
      pal_mem[i] = '0;
      pal_written[i] = 1'b0;
    end

    // reset values, palette extremes, palette disable, transparent material, saturation
    steps.push_back(pix(8'd192, 1'b1, 1, 16'h0000, 8'hFF));
    steps.push_back(pix(8'd255, 1'b0, 1, 16'h0000, 8'hFF));
    steps.push_back(pal(8'd0, 24'hFFFFFF));
    steps.push_back(pal(8'd191, 24'h000000));
    steps.push_back(pal(8'd255, 24'h5AA53C));
    steps.push_back(pal(8'd100, 24'h123456));
    steps.push_back(pix(8'd0, 1'b0, 1, 16'hFFFF, 8'hFF));
    steps.push_back(pix(8'd191, 1'b0, 1, 16'h0000, 8'hFF));
    steps.push_back(pix(8'd100, 1'b0));
    steps.push_back(reg_wr(REG_ALLOW_PAL, 32'd0));
    steps.push_back(reg_wr(REG_BASE_ALPHA, 32'd0));
    steps.push_back(pix(8'd0, 1'b0, 1, TRANSPARENT_VALUE, 8'h00));
    steps.push_back(reg_wr(REG_MAT_LO, {TRANSPARENT_VALUE, 16'hFFFF}));
    steps.push_back(reg_wr(REG_MAT_HI, 32'h8410_0001));
    steps.push_back(reg_wr(REG_MAT_ALPHA, 32'h017F_8000));
    steps.push_back(pix(8'd207, 1'b0, 1, 16'hFFFF, 8'h00));
    steps.push_back(pix(8'd208, 1'b0, 1, TRANSPARENT_VALUE, 8'h00));
    steps.push_back(pix(8'd240, 1'b0, 1, 16'h0000, 8'h01));
    steps.push_back(pix(8'd239, 1'b0));
    steps.push_back(reg_wr(REG_BASE_ALPHA, 32'hFF));
    steps.push_back(reg_wr(REG_ALLOW_PAL, 32'd1));
    steps.push_back(reg_wr(REG_RUST, 32'hFF03_0201));
    steps.push_back(reg_wr(REG_BURN, 32'h0102_03FF));
    // rust and burn, seed reload on image start
    steps.push_back(pix(8'd207, 1'b1));
    steps.push_back(pix(8'd207, 1'b0));
    steps.push_back(pix(8'd231, 1'b0));
    steps.push_back(pix(8'd247, 1'b0));
    steps.push_back(pix(8'd255, 1'b1));
    steps.push_back(pix(8'd0, 1'b1));
    steps.push_back(pix(8'd200, 1'b0));
    steps.push_back(pix(8'd100, 1'b0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[k]) begin
      if (steps[k].kind == STEP_REG) begin
        wait_idle();
        write_reg(steps[k].idx, steps[k].value);
      end else begin
        send_item(steps[k].item, steps[k].typed, steps[k].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == PHASES - 1) quiet = 1'b1;
      case (ph)
        0: begin
          write_reg(REG_MAT_LO, '0);
          write_reg(REG_MAT_HI, '0);
          write_reg(REG_RUST, '0);
          write_reg(REG_BURN, '0);
          write_reg(REG_MAT_ALPHA, '0);
          write_reg(REG_BASE_ALPHA, '0);
          write_reg(REG_ALLOW_PAL, '0);
        end
        1: begin
          write_reg(REG_MAT_LO, '1);
          write_reg(REG_MAT_HI, '1);
          write_reg(REG_RUST, '1);
          write_reg(REG_BURN, '1);
          write_reg(REG_MAT_ALPHA, '1);
          write_reg(REG_BASE_ALPHA, 32'hFF);
          write_reg(REG_ALLOW_PAL, 32'd1);
        end
        default: begin
          write_reg(REG_MAT_LO, {mix_color(), mix_color()});
          write_reg(REG_MAT_HI, {mix_color(), mix_color()});
          write_reg(REG_RUST, {mix_byte(), mix_byte(), mix_byte(), mix_byte()});
          write_reg(REG_BURN, {mix_byte(), mix_byte(), mix_byte(), mix_byte()});
          write_reg(REG_MAT_ALPHA, {mix_byte(), mix_byte(), mix_byte(), mix_byte()});
          write_reg(REG_BASE_ALPHA, {24'($urandom), mix_byte()});
          write_reg(REG_ALLOW_PAL, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = in_t'(42'({$urandom, $urandom}));
        if ($urandom_range(0, 4) == 0) begin
          it.req_type = 1'b1;
        end else begin
          it.req_type = 1'b0;
          it.image_start = ($urandom_range(0, 19) == 0);
          if (pal_codes.size() != 0 && $urandom_range(0, 1) == 0)
            it.pixel_code = pal_codes[$urandom_range(0, pal_codes.size() - 1)];
          else
            it.pixel_code = 8'($urandom_range(192, 255));
        end
        send_item(it, 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
